// File: rtl/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg: shared types and constants for the ranged MT19937 generator
// Holds the generator constants, the tempering function and the request and
// response structs that pass between the sequencer, the divider and the top.
// ----------------------------------------------------------------------------
package mtr_pkg;

  // State array geometry
  localparam int unsigned N_WORDS  = 624;
  localparam int unsigned M_OFFSET = 397;
  localparam int unsigned IDX_W    = 10;

  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(N_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_ALL_USED = IDX_W'(N_WORDS);
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(N_WORDS + 1);
  localparam logic [IDX_W-1:0] IDX_M        = IDX_W'(M_OFFSET);
  localparam logic [IDX_W-1:0] IDX_N        = IDX_W'(N_WORDS);

  // Generator constants
  localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;
  localparam logic [31:0] INIT_MULT  = 32'h6C07_8965;
  localparam logic [31:0] SEED_RESET = 32'd5489;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;

  // Word request to the state sequencer and its response
  typedef struct packed {
    logic        start;
    logic [31:0] seed;
  } gen_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] word;
  } gen_rsp_t;

  // Remainder request to the serial divider and its response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] remainder;
  } div_rsp_t;

  // Standard MT19937 output tempering
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: rtl/mtr_mod.sv
// ----------------------------------------------------------------------------
// mtr_mod: serial remainder unit
// Restoring division of a 32-bit word by a 16-bit limit, one dividend bit per
// cycle through a shared 17-bit compare and subtract. A zero limit gives 0.
// ----------------------------------------------------------------------------
module mtr_mod (
  input  logic               clk,
  input  logic               rst,
  input  mtr_pkg::div_req_t  req,
  output mtr_pkg::div_rsp_t  rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic [16:0] diff;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[31]};
    diff  = trial - {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the partial remainder below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[30:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[15:0];
      end else begin
        rem <= trial[15:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = (dvs == 16'd0) ? 16'd0 : rem;

endmodule

// File: rtl/mtr_state.sv
// ----------------------------------------------------------------------------
// mtr_state: MT19937 state memory and sequencer
// Keeps the 624-word state in a RAM with one write and two registered read
// ports. A small sequencer seeds it (one shared multiplier: multiply, write),
// twists it in place (read, read, write per word) and reads out tempered words.
// ----------------------------------------------------------------------------
module mtr_state (
  input  logic               clk,
  input  logic               rst,
  input  mtr_pkg::gen_req_t  req,
  output mtr_pkg::gen_rsp_t  rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SMUL = 3'd1;
  localparam logic [2:0] S_SWR  = 3'd2;
  localparam logic [2:0] S_TRD0 = 3'd3;
  localparam logic [2:0] S_TRD1 = 3'd4;
  localparam logic [2:0] S_TWR  = 3'd5;
  localparam logic [2:0] S_ORD  = 3'd6;
  localparam logic [2:0] S_OTMP = 3'd7;

  logic [2:0]                   state;
  logic [mtr_pkg::IDX_W-1:0]    idx;
  logic [mtr_pkg::IDX_W-1:0]    cnt;
  logic [31:0]                  prev;
  logic [31:0]                  prod;
  logic                         upper;
  logic [31:0]                  mid;
  logic                         done;
  logic [31:0]                  word;

  logic [31:0]                  mem [mtr_pkg::N_WORDS];
  logic                         we;
  logic [mtr_pkg::IDX_W-1:0]    wa;
  logic [31:0]                  wd;
  logic [mtr_pkg::IDX_W-1:0]    ra_a;
  logic [mtr_pkg::IDX_W-1:0]    ra_b;
  logic [31:0]                  rda;
  logic [31:0]                  rdb;

  logic [mtr_pkg::IDX_W-1:0]    cnt_m;
  logic [mtr_pkg::IDX_W-1:0]    cnt_inc;
  logic [31:0]                  tw_y;
  logic [31:0]                  tw_v;
  logic [31:0]                  seed_v;

  // State RAM
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda <= mem[ra_a];
    rdb <= mem[ra_b];
  end

  // Twist and seed arithmetic
  always_comb begin
    cnt_m   = cnt + mtr_pkg::IDX_M;
    if (cnt_m >= mtr_pkg::IDX_N) begin
      cnt_m = cnt_m - mtr_pkg::IDX_N;
    end
    cnt_inc = (cnt == mtr_pkg::IDX_LAST) ? '0 : cnt + 1'b1;
    tw_y    = {upper, rda[30:0]};
    tw_v    = mid ^ (tw_y >> 1) ^ (rda[0] ? mtr_pkg::MATRIX_A : 32'd0);
    seed_v  = prod + {{(32 - mtr_pkg::IDX_W){1'b0}}, cnt};
  end

  // RAM port control by sequencer state
  always_comb begin
    we   = 1'b0;
    wa   = cnt;
    wd   = tw_v;
    ra_a = cnt;
    ra_b = cnt_m;
    case (state)
      S_IDLE: begin
        if (req.start && idx == mtr_pkg::IDX_UNSEEDED) begin
          we = 1'b1;
          wa = '0;
          wd = req.seed;
        end
      end
      S_SWR: begin
        we = 1'b1;
        wd = seed_v;
      end
      S_TRD1: begin
        ra_a = cnt_inc;
      end
      S_TWR: begin
        we = 1'b1;
      end
      S_ORD: begin
        ra_a = idx;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= mtr_pkg::IDX_UNSEEDED;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            if (idx == mtr_pkg::IDX_UNSEEDED) begin
              cnt   <= 10'd1;
              state <= S_SMUL;
            end else if (idx >= mtr_pkg::IDX_ALL_USED) begin
              cnt   <= '0;
              state <= S_TRD0;
            end else begin
              state <= S_ORD;
            end
          end
        end
        S_SMUL: state <= S_SWR;
        S_SWR: begin
          if (cnt == mtr_pkg::IDX_LAST) begin
            cnt   <= '0;
            state <= S_TRD0;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_SMUL;
          end
        end
        S_TRD0: state <= S_TRD1;
        S_TRD1: state <= S_TWR;
        S_TWR: begin
          if (cnt == mtr_pkg::IDX_LAST) begin
            idx   <= '0;
            state <= S_ORD;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_TRD0;
          end
        end
        S_ORD: state <= S_OTMP;
        S_OTMP: begin
          idx   <= idx + 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.start) begin
      prev <= req.seed;
    end
    if (state == S_SMUL) begin
      prod <= (prev ^ (prev >> 30)) * mtr_pkg::INIT_MULT;
    end
    if (state == S_SWR) begin
      prev <= seed_v;
    end
    if (state == S_TRD1) begin
      upper <= rda[31];
      mid   <= rdb;
    end
    if (state == S_OTMP) begin
      word <= mtr_pkg::temper(rda);
    end
  end

  assign rsp.done = done;
  assign rsp.word = word;

  // Checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= mtr_pkg::IDX_UNSEEDED)
    else $error("word index out of range");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ORD |-> idx < mtr_pkg::IDX_ALL_USED)
    else $error("readout of a used-up index");

  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_OTMP)
    else $error("word done without a readout");

endmodule

// File: rtl/mersenne_twister_ranged_rng.sv
// ----------------------------------------------------------------------------
// mersenne_twister_ranged_rng: MT19937 generator with range reduction
// Returns the next tempered MT19937 word per request, with that word taken
// modulo the request's limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, range_limit) carries one request.
//   Output channel (out_valid, out_stall, raw_word, reduced_word) returns
//   exactly one result per request, in order.
//   APB port: register seed_value at byte address 0, read and write.
// Sequence:
//   An ordinary request passes from accept to out_valid through the state RAM
//   read and tempering, then the serial remainder unit, then the handshake
//   registers. One request is in work at a time, so the next request is
//   taken only once the last one's result has moved to the output register.
//   Every 624th request first twists the state, word by word.
//   The first request after reset also seeds the state from seed_value,
//   word by word through the shared multiplier.
// Reset leaves the generator unseeded and seed_value at 5489. A stalled
// result sits in the output register; the next request is still accepted
// and waits there before loading once the register is free.
// ----------------------------------------------------------------------------
module mersenne_twister_ranged_rng (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] range_limit,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] raw_word,
  output logic [15:0] reduced_word,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_GEN  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;
  localparam logic [1:0] T_HOLD = 2'd3;

  localparam logic REG_SEED = 1'b0;

  logic [1:0]        tstate;
  logic [31:0]       seed_value;
  logic [15:0]       lim;
  logic [15:0]       rem_hold;
  logic              in_take;
  logic              load;

  mtr_pkg::gen_req_t gen_req;
  mtr_pkg::gen_rsp_t gen_rsp;
  mtr_pkg::div_req_t div_req;
  mtr_pkg::div_rsp_t div_rsp;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED) ? seed_value : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= mtr_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SEED) begin
      seed_value <= pwdata;
    end
  end

  // Request handshake: hold off during reset and while a request is in work
  assign in_stall = rst || (tstate != T_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign load     = (tstate == T_HOLD) && (!out_valid || !out_stall);

  assign gen_req.start = in_take;
  assign gen_req.seed  = seed_value;

  assign div_req.start    = gen_rsp.done;
  assign div_req.dividend = gen_rsp.word;
  assign div_req.divisor  = lim;

  mtr_state u_state (
    .clk (clk),
    .rst (rst),
    .req (gen_req),
    .rsp (gen_rsp)
  );

  mtr_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Request sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= T_IDLE;
    end else begin
      case (tstate)
        T_IDLE: if (in_take)      tstate <= T_GEN;
        T_GEN:  if (gen_rsp.done) tstate <= T_DIV;
        T_DIV:  if (div_rsp.done) tstate <= T_HOLD;
        T_HOLD: if (load)         tstate <= T_IDLE;
        default: tstate <= T_IDLE;
      endcase
    end
  end

  // Hold the limit and the finished remainder
  always_ff @(posedge clk) begin
    if (in_take) begin
      lim <= range_limit;
    end
    if (div_rsp.done) begin
      rem_hold <= div_rsp.remainder;
    end
  end

  // Output register: drop on take, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      raw_word     <= gen_rsp.word;
      reduced_word <= rem_hold;
    end
  end

  // Checks
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("second request taken while one is in work");

  a_gen_when_waiting: assert property (@(posedge clk) disable iff (rst)
    gen_rsp.done |-> tstate == T_GEN)
    else $error("word arrived outside generate phase");

  a_div_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> tstate == T_DIV)
    else $error("remainder arrived outside divide phase");

  a_rem_below_limit: assert property (@(posedge clk) disable iff (rst)
    (load && lim != 16'd0) |-> rem_hold < lim)
    else $error("remainder not below limit");

endmodule

// File: test/tb_mersenne_twister_ranged_rng.sv
// ----------------------------------------------------------------------------
// tb_mersenne_twister_ranged_rng: self-checking bench for the ranged MT19937
// Drives range limits into the request channel and checks every raw and
// reduced word against an in-bench MT19937 predictor. Seeds are written over
// the APB port before the first request and between phases. Both sides idle
// and stall at random, with a long result hold-off and a calm phase.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_ranged_rng;

  localparam int unsigned MT_LEN     = 624;
  localparam int unsigned MT_SHIFT   = 397;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT  = 32'h6C07_8965;
  localparam logic [31:0] HI_BIT     = 32'h8000_0000;
  localparam logic [31:0] LO_BITS    = 32'h7FFF_FFFF;
  localparam logic [31:0] TEMPER_1   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_2   = 32'hEFC6_0000;
  localparam logic [31:0] POWERUP_SEED = 32'd5489;
  localparam int unsigned POS_SPENT    = 624;
  localparam int unsigned POS_UNSEEDED = 625;

  // APB register map: seed at index 0, index 1 is unmapped
  localparam logic [2:0] SEED_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  localparam int unsigned STALL_PCT   = 17;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER  = 400;
  localparam int unsigned PHASE_ITEMS = 310;
  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct packed {
    logic [31:0] raw;
    logic [15:0] reduced;
  } draw_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] range_limit = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] raw_word;
  logic [15:0] reduced_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [31:0] mt_words [MT_LEN];
  int unsigned mt_pos = POS_UNSEEDED;
  logic [31:0] seed_shadow = POWERUP_SEED;

  logic [15:0] limit_q [$];
  draw_t       pending_draws [$];

  bit          req_taken = 1'b0;
  bit          calm = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;

  mersenne_twister_ranged_rng dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_limit  (range_limit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raw_word     (raw_word),
    .reduced_word (reduced_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Fill the state array from a seed
  function automatic void seed_words(input logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int i = 1; i < MT_LEN; i++) begin
      p = mt_words[i-1];
      mt_words[i] = (p ^ (p >> 30)) * SEED_MULT + 32'(i);
    end
  endfunction

  // Regenerate all words in place
  function automatic void twist_words();
    logic [31:0] nxt;
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < MT_LEN; i++) begin
      nxt = mt_words[(i + 1) % MT_LEN];
      y = (mt_words[i] & HI_BIT) | (nxt & LO_BITS);
      v = mt_words[(i + MT_SHIFT) % MT_LEN] ^ (y >> 1);
      if (nxt[0]) v = v ^ TWIST_XOR;
      mt_words[i] = v;
    end
  endfunction

  // Produce the next draw for one request and advance the generator
  function automatic draw_t next_draw(input logic [15:0] limit);
    draw_t d;
    logic [31:0] y;
    if (mt_pos >= POS_SPENT) begin
      if (mt_pos == POS_UNSEEDED) seed_words(seed_shadow);
      twist_words();
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_1);
    y = y ^ ((y << 15) & TEMPER_2);
    y = y ^ (y >> 18);
    d.raw = y;
    d.reduced = (limit == 16'd0) ? 16'd0 : 16'(y % {16'd0, limit});
    return d;
  endfunction

  // Weight limits toward zero, the top value and small moduli
  function automatic logic [15:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(16, 1));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Sample both channels, predict, check, and watch for a hang
  always @(posedge clk) begin : sample
    draw_t want;
    bit    got_req;
    bit    got_rsp;
    got_req = !rst && in_valid && !in_stall;
    got_rsp = !rst && out_valid && !out_stall;
    req_taken = got_req;
    if (got_rsp) begin
      results_seen++;
      if (pending_draws.size() == 0) begin
        $error("result with no request waiting: raw_word %h reduced_word %h",
               raw_word, reduced_word);
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        if (raw_word !== want.raw) begin
          $error("raw_word expected %h actual %h", want.raw, raw_word);
          fail_count++;
        end
        if (reduced_word !== want.reduced) begin
          $error("reduced_word expected %0d actual %0d", want.reduced, reduced_word);
          fail_count++;
        end
      end
    end
    if (got_req) pending_draws.push_back(next_draw(range_limit));
    if (got_req || got_rsp || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Request driver: hold the payload until taken, idle at random
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (limit_q.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
        in_valid <= 1'b1;
        range_limit <= limit_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end
  end

  // Write one register through setup and access cycles
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == SEED_ADDR) seed_shadow = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every queued request has been sent and has its result
  task automatic wait_drained();
    while (limit_q.size() != 0 || in_valid || pending_draws.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    for (int i = 0; i < count; i++) limit_q.push_back(pick_limit());
    wait_drained();
  endtask

  initial begin
    logic [15:0] directed [16] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFE,
                                   16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'd7,
                                   16'd10, 16'd0, 16'd1000, 16'h00FF, 16'hFF00};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Seed before the first request: the last write is the one used
    apb_write(SEED_ADDR, 32'h0000_0000);
    apb_write(SEED_ADDR, 32'hFFFF_FFFF);
    apb_write(SPARE_ADDR, $urandom);
    apb_write(SEED_ADDR, $urandom);

    // Directed limits, the first one also seeds and twists
    foreach (directed[i]) limit_q.push_back(directed[i]);
    wait_drained();

    // Later seed writes must not reseed the generator
    apb_write(SEED_ADDR, 32'h0000_0000);
    run_random(PHASE_ITEMS);

    apb_write(SEED_ADDR, 32'hFFFF_FFFF);
    apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
    run_random(PHASE_ITEMS);

    // Run one phase at full rate on both sides
    apb_write(SEED_ADDR, $urandom);
    calm = 1'b1;
    run_random(PHASE_ITEMS);
    calm = 1'b0;

    apb_write(SEED_ADDR, POWERUP_SEED);
    run_random(PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mtr_pkg.sv
rtl/mtr_mod.sv
rtl/mtr_state.sv
rtl/mersenne_twister_ranged_rng.sv
test/tb_mersenne_twister_ranged_rng.sv
